[src/tgr_pkg.sv]
// shared types, codes and helpers of the touch gesture recognizer
// no dependencies; imported by every module of the block
package tgr_pkg;

   localparam logic [15:0] TAP_DISTANCE = 16'd30;

   typedef enum logic [2:0] {
      G_NONE   = 3'd0,
      G_TAP    = 3'd1,
      G_DOUBLE = 3'd2,
      G_LONG   = 3'd3,
      G_LEFT   = 3'd4,
      G_RIGHT  = 3'd5,
      G_UP     = 3'd6,
      G_DOWN   = 3'd7
   } gesture_type;

   typedef enum logic [2:0] {
      REG_ROTATION       = 3'd0,
      REG_RAW_WIDTH      = 3'd1,
      REG_RAW_HEIGHT     = 3'd2,
      REG_LONG_PRESS_MS  = 3'd3,
      REG_LONG_PRESS_MAX = 3'd4,
      REG_SWIPE_THRESH   = 3'd5,
      REG_TAP_MAX_MS     = 3'd6,
      REG_DOUBLE_TAP_MS  = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      ROT_0   = 2'd0,
      ROT_90  = 2'd1,
      ROT_180 = 2'd2,
      ROT_270 = 2'd3
   } rotation_type;

   typedef struct packed {
      logic [1:0]  rotation;
      logic [11:0] raw_width;
      logic [11:0] raw_height;
      logic [15:0] long_press_ms;
      logic [11:0] long_press_max_move;
      logic [11:0] swipe_threshold;
      logic [15:0] tap_max_ms;
      logic [15:0] double_tap_ms;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  touch_count;
      logic [11:0] raw_x;
      logic [11:0] raw_y;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic        touched;
      logic        pressed;
      logic        moved;
      logic        released;
      logic [2:0]  gesture;
      logic        event_valid;
   } rsp_type;

   typedef struct packed {
      logic        active;
      logic [15:0] start_x;
      logic [15:0] start_y;
      logic [15:0] last_x;
      logic [15:0] last_y;
      logic [31:0] start_time;
      logic        long_fired;
      logic        tap_pending;
      logic [31:0] last_tap_time;
      logic [15:0] last_tap_x;
      logic [15:0] last_tap_y;
   } state_type;

   function automatic logic [15:0] mag_diff(input logic [15:0] a, input logic [15:0] b);
      mag_diff = (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

[src/tgr_if.sv]
// handshake channels of the touch gesture recognizer: report in, result out
// no dependencies
interface tgr_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  touch_count;
   logic [11:0] raw_x;
   logic [11:0] raw_y;
   logic [31:0] now_ms;

   modport source (output valid, touch_count, raw_x, raw_y, now_ms, input ready);
   modport sink (input valid, touch_count, raw_x, raw_y, now_ms, output ready);
endinterface

interface tgr_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pos_x;
   logic [15:0] pos_y;
   logic        touched;
   logic        pressed;
   logic        moved;
   logic        released;
   logic [2:0]  gesture;
   logic        event_valid;

   modport source (output valid, pos_x, pos_y, touched, pressed, moved, released, gesture,
                   event_valid, input ready);
   modport sink (input valid, pos_x, pos_y, touched, pressed, moved, released, gesture,
                 event_valid, output ready);
endinterface

[src/touch_gesture_recognizer.sv]
// touch gesture recognizer: report register, gesture step, state and result register
// an accepted beat is held in the report register, and its result is registered for rsp
// throughput one beat per cycle while rsp is not stalled, set by the state update in tgr_step
// the result register parts the two sides, so a new beat enters an empty report register while a result waits
// synchronous active-high reset returns all gesture state to zero and the configuration
// registers to their defaults at once; no clearing pass
module touch_gesture_recognizer
   import tgr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tgr_req_if.sink     req_ch,
   tgr_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type   cfg;
   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_item_ff;
   logic      out_valid_ff;
   logic      out_valid_in;
   rsp_type   out_item_ff;
   state_type state_ff;
   state_type state_next;
   rsp_type   step_result;
   logic      req_fire;
   logic      step_fire;

   tgr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tgr_step u_step (
      .cfg        (cfg),
      .state      (state_ff),
      .item       (in_item_ff),
      .state_next (state_next),
      .result     (step_result)
   );

   // the held beat moves on when the result register is empty or being drained
   assign step_fire    = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || step_fire;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign in_valid_in  = req_fire ? 1'b1 : (step_fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = step_fire ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step_fire) begin
            state_ff <= state_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.touch_count <= req_ch.touch_count;
         in_item_ff.raw_x       <= req_ch.raw_x;
         in_item_ff.raw_y       <= req_ch.raw_y;
         in_item_ff.now_ms      <= req_ch.now_ms;
      end
      if (step_fire) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.pos_x       = out_item_ff.pos_x;
   assign rsp_ch.pos_y       = out_item_ff.pos_y;
   assign rsp_ch.touched     = out_item_ff.touched;
   assign rsp_ch.pressed     = out_item_ff.pressed;
   assign rsp_ch.moved       = out_item_ff.moved;
   assign rsp_ch.released    = out_item_ff.released;
   assign rsp_ch.gesture     = out_item_ff.gesture;
   assign rsp_ch.event_valid = out_item_ff.event_valid;

endmodule

[src/tgr_csr.sv]
// apb-style configuration registers of the touch gesture recognizer
// depends on tgr_pkg
module tgr_csr
   import tgr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign index      = reg_index_type'(csr_paddr[4:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_ROTATION:       cfg_in.rotation            = csr_pwdata[1:0];
            REG_RAW_WIDTH:      cfg_in.raw_width           = csr_pwdata[11:0];
            REG_RAW_HEIGHT:     cfg_in.raw_height          = csr_pwdata[11:0];
            REG_LONG_PRESS_MS:  cfg_in.long_press_ms       = csr_pwdata[15:0];
            REG_LONG_PRESS_MAX: cfg_in.long_press_max_move = csr_pwdata[11:0];
            REG_SWIPE_THRESH:   cfg_in.swipe_threshold     = csr_pwdata[11:0];
            REG_TAP_MAX_MS:     cfg_in.tap_max_ms          = csr_pwdata[15:0];
            REG_DOUBLE_TAP_MS:  cfg_in.double_tap_ms       = csr_pwdata[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_ROTATION:       csr_prdata = {30'd0, cfg_ff.rotation};
         REG_RAW_WIDTH:      csr_prdata = {20'd0, cfg_ff.raw_width};
         REG_RAW_HEIGHT:     csr_prdata = {20'd0, cfg_ff.raw_height};
         REG_LONG_PRESS_MS:  csr_prdata = {16'd0, cfg_ff.long_press_ms};
         REG_LONG_PRESS_MAX: csr_prdata = {20'd0, cfg_ff.long_press_max_move};
         REG_SWIPE_THRESH:   csr_prdata = {20'd0, cfg_ff.swipe_threshold};
         REG_TAP_MAX_MS:     csr_prdata = {16'd0, cfg_ff.tap_max_ms};
         REG_DOUBLE_TAP_MS:  csr_prdata = {16'd0, cfg_ff.double_tap_ms};
         default:            csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotation            <= 2'd0;
         cfg_ff.raw_width           <= 12'd0;
         cfg_ff.raw_height          <= 12'd0;
         cfg_ff.long_press_ms       <= 16'd1000;
         cfg_ff.long_press_max_move <= 12'd10;
         cfg_ff.swipe_threshold     <= 12'd50;
         cfg_ff.tap_max_ms          <= 16'd200;
         cfg_ff.double_tap_ms       <= 16'd300;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/tgr_step.sv]
// one report's worth of gesture logic: rotation, press tracking, long-press, tap and swipe decode
// depends on tgr_pkg; purely combinational, state registers live in the top level
module tgr_step
   import tgr_pkg::*;
(
   input  cfg_type   cfg,
   input  state_type state,
   input  req_type   item,
   output state_type state_next,
   output rsp_type   result
);

   logic        touched;
   logic [15:0] x;
   logic [15:0] y;
   logic [15:0] rx;
   logic [15:0] ry;
   logic [15:0] w_minus_x;
   logic [15:0] h_minus_y;
   logic        still;
   logic [15:0] adx;
   logic [15:0] ady;
   logic [31:0] duration;
   logic [31:0] hold_time;
   logic        same;
   logic        done;
   gesture_type gesture;
   state_type   s;

   assign touched   = item.touch_count != 4'd0;
   assign rx        = {4'd0, item.raw_x};
   assign ry        = {4'd0, item.raw_y};
   assign w_minus_x = {4'd0, cfg.raw_width} - rx;
   assign h_minus_y = {4'd0, cfg.raw_height} - ry;

   always_comb begin
      case (rotation_type'(cfg.rotation))
         ROT_90: begin
            x = ry;
            y = w_minus_x;
         end
         ROT_180: begin
            x = w_minus_x;
            y = h_minus_y;
         end
         ROT_270: begin
            x = h_minus_y;
            y = rx;
         end
         default: begin
            x = rx;
            y = ry;
         end
      endcase
   end

   // release distances use the stored path, not this report's position
   assign adx      = mag_diff(state.last_x, state.start_x);
   assign ady      = mag_diff(state.last_y, state.start_y);
   assign duration = item.now_ms - state.start_time;
   assign same     = (mag_diff(state.start_x, state.last_tap_x) < TAP_DISTANCE) &&
                     (mag_diff(state.start_y, state.last_tap_y) < TAP_DISTANCE);

   always_comb begin
      s       = state;
      gesture = G_NONE;
      done    = 1'b0;
      result  = '0;
      still   = 1'b0;
      hold_time = 32'd0;

      if (touched) begin
         s.last_x = x;
         s.last_y = y;
         if (!state.active) begin
            s.active     = 1'b1;
            s.start_time = item.now_ms;
            s.start_x    = x;
            s.start_y    = y;
            s.long_fired = 1'b0;
            result.pressed = 1'b1;
         end
         still = (mag_diff(x, s.start_x) < {4'd0, cfg.long_press_max_move}) &&
                 (mag_diff(y, s.start_y) < {4'd0, cfg.long_press_max_move});
         hold_time = item.now_ms - s.start_time;
         if (!s.long_fired && still && (hold_time > {16'd0, cfg.long_press_ms})) begin
            s.long_fired = 1'b1;
            gesture      = G_LONG;
         end else begin
            result.moved = 1'b1;
         end
      end else if (state.active) begin
         s.active        = 1'b0;
         result.released = 1'b1;
         if ((adx > {4'd0, cfg.swipe_threshold}) || (ady > {4'd0, cfg.swipe_threshold})) begin
            if (adx > ady) begin
               gesture = (state.last_x > state.start_x) ? G_RIGHT : G_LEFT;
            end else begin
               gesture = (state.last_y > state.start_y) ? G_DOWN : G_UP;
            end
            done = 1'b1;
         end else if ((duration < {16'd0, cfg.tap_max_ms}) && !state.long_fired) begin
            if (state.tap_pending && same &&
                ((item.now_ms - state.last_tap_time) < {16'd0, cfg.double_tap_ms})) begin
               s.tap_pending = 1'b0;
               gesture       = G_DOUBLE;
            end else begin
               gesture         = G_TAP;
               s.tap_pending   = 1'b1;
               s.last_tap_time = item.now_ms;
               s.last_tap_x    = state.start_x;
               s.last_tap_y    = state.start_y;
            end
            done = 1'b1;
         end
      end

      // a pending tap that outlived the window fires late, over any long press
      if (done) begin
         result.event_valid = 1'b1;
      end else if (s.tap_pending &&
                   ((item.now_ms - s.last_tap_time) > {16'd0, cfg.double_tap_ms})) begin
         s.tap_pending      = 1'b0;
         gesture            = G_TAP;
         result.event_valid = 1'b1;
      end else begin
         result.event_valid = touched;
      end

      result.pos_x   = s.last_x;
      result.pos_y   = s.last_y;
      result.touched = touched;
      result.gesture = gesture;
   end

   assign state_next = s;

endmodule

[src/tgr_checker.sv]
// port-level assertions for the touch gesture recognizer, bound to the top level
// depends on tgr_pkg and touch_gesture_recognizer
module tgr_checker
   import tgr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_pos_x,
   input logic [15:0] rsp_pos_y,
   input logic        rsp_touched,
   input logic        rsp_pressed,
   input logic        rsp_moved,
   input logic        rsp_released,
   input logic [2:0]  rsp_gesture,
   input logic        rsp_event_valid
);

   // a stalled result beat holds its valid, position, gesture and event flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y) &&
      $stable(rsp_gesture) && $stable(rsp_event_valid))
      else $error("result beat changed while stalled");

   // press and move come only with a touch, release only without one, and a touch carries event_valid
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_pressed || rsp_touched) && (!rsp_moved || rsp_touched) &&
      (!rsp_released || !rsp_touched) && (!rsp_touched || rsp_event_valid))
      else $error("inconsistent touch flags");

   // a long press replaces the move flag on a held touch
   a_long: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_gesture == G_LONG) |-> rsp_touched && !rsp_moved && rsp_event_valid)
      else $error("long press without a still touch");

   // swipes are decided only on release
   a_swipe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_gesture == G_LEFT) || (rsp_gesture == G_RIGHT) ||
      (rsp_gesture == G_UP) || (rsp_gesture == G_DOWN)) |-> rsp_released && rsp_event_valid)
      else $error("swipe without release");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind touch_gesture_recognizer tgr_checker u_tgr_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_pos_x       (rsp_ch.pos_x),
   .rsp_pos_y       (rsp_ch.pos_y),
   .rsp_touched     (rsp_ch.touched),
   .rsp_pressed     (rsp_ch.pressed),
   .rsp_moved       (rsp_ch.moved),
   .rsp_released    (rsp_ch.released),
   .rsp_gesture     (rsp_ch.gesture),
   .rsp_event_valid (rsp_ch.event_valid)
);
